### src/shake_and_motion_detector_defines.svh
// Assertion macros for the shake and motion detector.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef SHAKE_AND_MOTION_DETECTOR_DEFINES_SVH
`define SHAKE_AND_MOTION_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define SMD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smd assertion failed");

// Next-cycle implication, disabled during reset.
`define SMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smd assertion failed");

`else

`define SMD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SMD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### src/smd_pkg.sv
// Shared types and constants for the shake and motion detector.
// No dependencies; imported by the configuration channel interface, the top level and the testbench.
package smd_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_TIME_W = 24;
    localparam int DELTA_W    = 16;
    localparam int NEED_W     = 4;
    localparam int LEVEL_W    = 2;
    localparam int HIT_W      = 8;
    localparam int THR_W      = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_DELTA  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_NEED   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_COOL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAKE_NEED    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAKE_WINDOW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAKE_COOL    = 3'd6;

    localparam logic [LEVEL_W-1:0] LEVEL_LOW = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_MID = 2'd1;

    localparam logic [LEVEL_W-1:0]    RST_SENSITIVITY  = 2'd1;
    localparam logic [DELTA_W-1:0]    RST_MOTION_DELTA = 16'd1128;
    localparam logic [NEED_W-1:0]     RST_MOTION_NEED  = 4'd2;
    localparam logic [CFG_TIME_W-1:0] RST_MOTION_COOL  = 24'd1200000;
    localparam logic [NEED_W-1:0]     RST_SHAKE_NEED   = 4'd3;
    localparam logic [CFG_TIME_W-1:0] RST_SHAKE_WINDOW = 24'd500000;
    localparam logic [CFG_TIME_W-1:0] RST_SHAKE_COOL   = 24'd900000;

    localparam logic [THR_W-1:0] GRAVITY_COUNTS = 14'd8192;
    localparam logic [THR_W-1:0] SHAKE_THR_LOW  = 14'd6683;
    localparam logic [THR_W-1:0] SHAKE_THR_MID  = 14'd10024;
    localparam logic [THR_W-1:0] SHAKE_THR_HIGH = 14'd13366;
    localparam logic [HIT_W-1:0] HIT_MAX        = 8'd255;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_TIME,
        ST_DECIDE
    } t_state;

    typedef enum logic [1:0] {
        TCHK_MOTION_COOL,
        TCHK_SHAKE_WINDOW,
        TCHK_SHAKE_COOL
    } t_time_check;

    function automatic logic [THR_W-1:0] f_shake_thr(input logic [LEVEL_W-1:0] level);
        logic [THR_W-1:0] thr;
        priority if (level == LEVEL_LOW) begin
            thr = SHAKE_THR_LOW;
        end else if (level == LEVEL_MID) begin
            thr = SHAKE_THR_MID;
        end else begin
            thr = SHAKE_THR_HIGH;
        end
        return thr;
    endfunction

    function automatic logic [HIT_W-1:0] f_sat_inc(input logic [HIT_W-1:0] cnt);
        return (cnt == HIT_MAX) ? cnt : cnt + HIT_W'(1);
    endfunction

endpackage

### src/smd_intf.sv
// Valid/ready channel interfaces for samples, results and configuration writes.
// Depends on smd_pkg for configuration field widths.
interface smd_in_if #(
    parameter int ACCEL_BITS = 16,
    parameter int TIME_BITS  = 48
);
    logic                         valid;
    logic                         ready;
    logic signed [ACCEL_BITS-1:0] accel_x;
    logic signed [ACCEL_BITS-1:0] accel_y;
    logic signed [ACCEL_BITS-1:0] accel_z;
    logic [TIME_BITS-1:0]         time_us;

    modport source (output valid, accel_x, accel_y, accel_z, time_us, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, time_us, output ready);
endinterface

interface smd_out_if;
    logic valid;
    logic ready;
    logic motion_event;
    logic shake_event;

    modport source (output valid, motion_event, shake_event, input ready);
    modport sink   (input valid, motion_event, shake_event, output ready);
endinterface

interface smd_cfg_if;
    import smd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/shake_and_motion_detector.sv
// Shake and motion detector top level; depends on smd_pkg, smd_intf and the defines header.
// A request is taken only in the idle state; squaring, the bit-pair square root loop, the time checks
// and the decision run in turn, and the decision waits while a posted result is not yet taken.
// Squares go through one shared multiplier, time checks through one shared subtract/compare.
// Reset (synchronous, active low) restores register defaults and clears all hit state.
`include "shake_and_motion_detector_defines.svh"

module shake_and_motion_detector #(
    parameter int ACCEL_BITS = 16,
    parameter int TIME_BITS  = 48
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    smd_in_if.sink     i_sample,
    smd_cfg_if.sink    i_cfg,
    smd_out_if.source  o_result
);
    import smd_pkg::*;

    localparam int SW        = 2 * ACCEL_BITS + 2;
    localparam int CW        = $clog2(ACCEL_BITS + 2);
    localparam int ROOT_LAST = ACCEL_BITS;
    localparam int SQ_LAST   = 3;
    localparam int TM_LAST   = 2;

    t_state r_state, n_state;
    logic [CW-1:0] r_step;

    logic [LEVEL_W-1:0]    r_sens;
    logic [DELTA_W-1:0]    r_motion_delta;
    logic [NEED_W-1:0]     r_motion_need;
    logic [CFG_TIME_W-1:0] r_motion_cool;
    logic [NEED_W-1:0]     r_shake_need;
    logic [CFG_TIME_W-1:0] r_shake_window;
    logic [CFG_TIME_W-1:0] r_shake_cool;

    logic [HIT_W-1:0]     r_motion_cnt, n_motion_cnt;
    logic [HIT_W-1:0]     r_shake_cnt, n_shake_cnt;
    logic [TIME_BITS-1:0] r_first_hit, n_first_hit;
    logic [TIME_BITS-1:0] r_last_shake, n_last_shake;
    logic [TIME_BITS-1:0] r_last_motion, n_last_motion;

    logic                  r_out_valid;
    logic                  r_out_motion, n_out_motion;
    logic                  r_out_shake, n_out_shake;

    logic [ACCEL_BITS-1:0]   r_ax, r_ay, r_az;
    logic [TIME_BITS-1:0]    r_now;
    logic [2*ACCEL_BITS-1:0] r_prod;
    logic [SW-1:0]           r_rem;
    logic [SW-1:0]           r_res;
    logic [SW-1:0]           r_bit;
    logic [SW-1:0]           r_delta;
    logic                    r_motion_ok;
    logic                    r_window_exp;
    logic                    r_shake_ok;

    logic in_ready;
    logic dec_go;
    logic step_last;

    logic [ACCEL_BITS-1:0] sq_sel;
    logic [SW:0]           root_trial;
    logic                  root_take;
    logic [TIME_BITS-1:0]  tm_ref;
    logic [TIME_BITS-1:0]  tm_thr;
    logic [TIME_BITS-1:0]  tm_diff;
    logic                  tm_pass;
    t_time_check           tm_sel;
    logic                  motion_hit;
    logic                  shake_hit;
    logic [HIT_W-1:0]      motion_inc;
    logic [HIT_W-1:0]      shake_next;

    function automatic logic [ACCEL_BITS-1:0] f_abs(input logic [ACCEL_BITS-1:0] v);
        return v[ACCEL_BITS-1] ? (~v + ACCEL_BITS'(1)) : v;
    endfunction

    assign i_cfg.ready           = 1'b1;
    assign i_sample.ready        = in_ready;
    assign o_result.valid        = r_out_valid;
    assign o_result.motion_event = r_out_motion;
    assign o_result.shake_event  = r_out_shake;

    // Sequencer control
    always_comb begin
        in_ready  = 1'b0;
        dec_go    = 1'b0;
        step_last = 1'b0;
        unique case (r_state)
            ST_IDLE:   in_ready  = 1'b1;
            ST_SQUARE: step_last = (r_step == CW'(SQ_LAST));
            ST_ROOT:   step_last = (r_step == CW'(ROOT_LAST));
            ST_TIME:   step_last = (r_step == CW'(TM_LAST));
            ST_DECIDE: dec_go    = !r_out_valid || o_result.ready;
            default:   in_ready  = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_sample.valid) n_state = ST_SQUARE;
            ST_SQUARE: if (step_last) n_state = ST_ROOT;
            ST_ROOT:   if (step_last) n_state = ST_TIME;
            ST_TIME:   if (step_last) n_state = ST_DECIDE;
            ST_DECIDE: if (dec_go) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Shared multiplier operand
    always_comb begin
        unique case (r_step[1:0])
            2'd0:    sq_sel = r_ax;
            2'd1:    sq_sel = r_ay;
            default: sq_sel = r_az;
        endcase
    end

    assign root_trial = {1'b0, r_res} + {1'b0, r_bit};
    assign root_take  = ({1'b0, r_rem} >= root_trial);

    // Shared time difference unit
    assign tm_sel = t_time_check'(r_step[1:0]);
    always_comb begin
        unique case (tm_sel)
            TCHK_MOTION_COOL: begin
                tm_ref = r_last_motion;
                tm_thr = TIME_BITS'(r_motion_cool);
            end
            TCHK_SHAKE_WINDOW: begin
                tm_ref = r_first_hit;
                tm_thr = TIME_BITS'(r_shake_window) + TIME_BITS'(1);
            end
            default: begin
                tm_ref = r_last_shake;
                tm_thr = TIME_BITS'(r_shake_cool) + TIME_BITS'(1);
            end
        endcase
    end
    assign tm_diff = r_now - tm_ref;
    assign tm_pass = (tm_diff >= tm_thr);

    // Event decision
    assign motion_hit = (r_delta >= SW'(r_motion_delta));
    assign shake_hit  = (r_delta >= SW'(f_shake_thr(r_sens)));
    assign motion_inc = f_sat_inc(r_motion_cnt);
    assign shake_next = ((r_shake_cnt == '0) || r_window_exp) ? HIT_W'(1)
                                                              : f_sat_inc(r_shake_cnt);

    always_comb begin
        n_motion_cnt  = r_motion_cnt;
        n_last_motion = r_last_motion;
        n_out_motion  = 1'b0;
        if (motion_hit) begin
            if ((motion_inc >= HIT_W'(r_motion_need)) && r_motion_ok) begin
                n_motion_cnt  = '0;
                n_last_motion = r_now;
                n_out_motion  = 1'b1;
            end else begin
                n_motion_cnt = motion_inc;
            end
        end else begin
            n_motion_cnt = '0;
        end

        n_shake_cnt  = r_shake_cnt;
        n_first_hit  = r_first_hit;
        n_last_shake = r_last_shake;
        n_out_shake  = 1'b0;
        if (shake_hit) begin
            if ((r_shake_cnt == '0) || r_window_exp) begin
                n_first_hit = r_now;
            end
            if ((shake_next >= HIT_W'(r_shake_need)) && r_shake_ok) begin
                n_shake_cnt  = '0;
                n_last_shake = r_now;
                n_out_shake  = 1'b1;
            end else begin
                n_shake_cnt = shake_next;
            end
        end else if ((r_shake_cnt != '0) && r_window_exp) begin
            n_shake_cnt = '0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_step         <= '0;
            r_out_valid    <= 1'b0;
            r_motion_cnt   <= '0;
            r_shake_cnt    <= '0;
            r_first_hit    <= '0;
            r_last_shake   <= '0;
            r_last_motion  <= '0;
            r_sens         <= RST_SENSITIVITY;
            r_motion_delta <= RST_MOTION_DELTA;
            r_motion_need  <= RST_MOTION_NEED;
            r_motion_cool  <= RST_MOTION_COOL;
            r_shake_need   <= RST_SHAKE_NEED;
            r_shake_window <= RST_SHAKE_WINDOW;
            r_shake_cool   <= RST_SHAKE_COOL;
        end else begin
            r_state <= n_state;
            if (r_state != n_state || r_state == ST_IDLE) begin
                r_step <= '0;
            end else begin
                r_step <= r_step + CW'(1);
            end

            if (r_state == ST_DECIDE && dec_go) begin
                r_out_valid   <= 1'b1;
                r_motion_cnt  <= n_motion_cnt;
                r_shake_cnt   <= n_shake_cnt;
                r_first_hit   <= n_first_hit;
                r_last_shake  <= n_last_shake;
                r_last_motion <= n_last_motion;
            end else if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_SENSITIVITY:  r_sens         <= i_cfg.data[LEVEL_W-1:0];
                    CFG_MOTION_DELTA: r_motion_delta <= i_cfg.data[DELTA_W-1:0];
                    CFG_MOTION_NEED:  r_motion_need  <= i_cfg.data[NEED_W-1:0];
                    CFG_MOTION_COOL:  r_motion_cool  <= i_cfg.data[CFG_TIME_W-1:0];
                    CFG_SHAKE_NEED:   r_shake_need   <= i_cfg.data[NEED_W-1:0];
                    CFG_SHAKE_WINDOW: r_shake_window <= i_cfg.data[CFG_TIME_W-1:0];
                    CFG_SHAKE_COOL:   r_shake_cool   <= i_cfg.data[CFG_TIME_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_ax  <= f_abs(i_sample.accel_x);
                r_ay  <= f_abs(i_sample.accel_y);
                r_az  <= f_abs(i_sample.accel_z);
                r_now <= i_sample.time_us;
                r_rem <= '0;
            end
            ST_SQUARE: begin
                r_prod <= sq_sel * sq_sel;
                if (r_step != '0) begin
                    r_rem <= r_rem + SW'(r_prod);
                end
                r_res <= '0;
                r_bit <= {2'b01, {(SW-2){1'b0}}};
            end
            ST_ROOT: begin
                if (root_take) begin
                    r_rem <= r_rem - root_trial[SW-1:0];
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            ST_TIME: begin
                if (r_step == '0) begin
                    r_delta <= (r_res >= SW'(GRAVITY_COUNTS)) ? r_res - SW'(GRAVITY_COUNTS)
                                                             : SW'(GRAVITY_COUNTS) - r_res;
                end
                unique case (tm_sel)
                    TCHK_MOTION_COOL:  r_motion_ok  <= tm_pass;
                    TCHK_SHAKE_WINDOW: r_window_exp <= tm_pass;
                    default:           r_shake_ok   <= tm_pass;
                endcase
            end
            ST_DECIDE: begin
                if (dec_go) begin
                    r_out_motion <= n_out_motion;
                    r_out_shake  <= n_out_shake;
                end
            end
            default: ;
        endcase
    end

    `SMD_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_sample.valid && in_ready, r_state == ST_SQUARE && r_step == '0)
    `SMD_ASSERT_SAME(a_root_bit_onehot, i_clk, i_rst_n, r_state == ST_ROOT, $onehot(r_bit))
    `SMD_ASSERT_SAME(a_root_range, i_clk, i_rst_n, r_state == ST_TIME, r_res[SW-1:ACCEL_BITS+1] == '0)
    `SMD_ASSERT_NEXT(a_decide_posts, i_clk, i_rst_n, r_state == ST_DECIDE && dec_go, r_state == ST_IDLE && r_out_valid)

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the shake and motion detector: directed table, then random phases.
// Depends on smd_pkg, the smd channel interfaces and the shake_and_motion_detector top level.
module tb;
    import smd_pkg::*;

    localparam int AW           = 16;
    localparam int TW           = 48;
    localparam int DRAIN_CYCLES = 40;
    localparam int ITEM_TARGET  = 1550;
    localparam int STEADY_ITEMS = 200;
    localparam int DIR_ROWS     = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 3'd7;
    localparam logic [LEVEL_W-1:0]   LEVEL_HIGH  = 2'd2;
    localparam logic [LEVEL_W-1:0]   LEVEL_ALIAS = 2'd3;

    typedef logic signed [AW-1:0] t_axis;
    typedef logic [TW-1:0]        t_stamp;

    typedef struct {
        t_axis  x;
        t_axis  y;
        t_axis  z;
        t_stamp t_us;
    } t_sample;

    typedef struct packed {
        logic motion;
        logic shake;
    } t_events;

    typedef struct {
        logic [LEVEL_W-1:0]    level;
        logic [DELTA_W-1:0]    motion_delta;
        logic [NEED_W-1:0]     motion_need;
        logic [CFG_TIME_W-1:0] motion_cool;
        logic [NEED_W-1:0]     shake_need;
        logic [CFG_TIME_W-1:0] shake_window;
        logic [CFG_TIME_W-1:0] shake_cool;
    } t_det_cfg;

    typedef struct {
        t_axis  x;
        t_axis  y;
        t_axis  z;
        t_stamp t_us;
        bit     typed;
        logic   motion;
        logic   shake;
    } t_dir_row;

    typedef enum {
        KIND_QUIET,
        KIND_MOTION,
        KIND_SHAKE,
        KIND_NOISE
    } t_kind;

    logic i_clk;
    logic i_rst_n;

    smd_in_if #(.ACCEL_BITS(AW), .TIME_BITS(TW)) sample_if ();
    smd_cfg_if cfg_if ();
    smd_out_if result_if ();

    shake_and_motion_detector #(
        .ACCEL_BITS(AW),
        .TIME_BITS (TW)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sample(sample_if),
        .i_cfg   (cfg_if),
        .o_result(result_if)
    );

    t_det_cfg         det_cfg;
    logic [HIT_W-1:0] pred_motion_cnt;
    logic [HIT_W-1:0] pred_shake_cnt;
    t_stamp           first_hit_t;
    t_stamp           last_shake_t;
    t_stamp           last_motion_t;

    t_events          expected_events[$];
    t_dir_row         dir_rows[DIR_ROWS];
    t_stamp           clock_us;
    int               items_sent;
    int               mismatch_count;
    int               ready_hold = 0;
    bit               steady_run;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [16:0] floor_root(input longint unsigned v);
        logic [16:0]       root;
        longint unsigned   cand;
        root = '0;
        for (int b = 16; b >= 0; b--) begin
            cand = root | (17'd1 << b);
            if (cand * cand <= v) begin
                root = cand[16:0];
            end
        end
        return root;
    endfunction

    function automatic longint unsigned axis_sq(input t_axis a);
        longint v;
        v = a;
        return longint'(v * v);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] field_mask(input logic [CFG_IDX_W-1:0] idx);
        logic [CFG_DATA_W-1:0] m;
        case (idx)
            CFG_SENSITIVITY:                 m = CFG_DATA_W'((1 << LEVEL_W) - 1);
            CFG_MOTION_DELTA:                m = CFG_DATA_W'((1 << DELTA_W) - 1);
            CFG_MOTION_NEED, CFG_SHAKE_NEED: m = CFG_DATA_W'((1 << NEED_W) - 1);
            default:                         m = '1;
        endcase
        return m;
    endfunction

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        case (idx)
            CFG_SENSITIVITY:  det_cfg.level        = d[LEVEL_W-1:0];
            CFG_MOTION_DELTA: det_cfg.motion_delta = d[DELTA_W-1:0];
            CFG_MOTION_NEED:  det_cfg.motion_need  = d[NEED_W-1:0];
            CFG_MOTION_COOL:  det_cfg.motion_cool  = d[CFG_TIME_W-1:0];
            CFG_SHAKE_NEED:   det_cfg.shake_need   = d[NEED_W-1:0];
            CFG_SHAKE_WINDOW: det_cfg.shake_window = d[CFG_TIME_W-1:0];
            CFG_SHAKE_COOL:   det_cfg.shake_cool   = d[CFG_TIME_W-1:0];
            default: ;
        endcase
    endtask

    task automatic compute_events(input t_sample s, output t_events ev);
        logic [16:0]      mag;
        logic [16:0]      dev;
        logic [THR_W-1:0] thr;
        t_stamp           dt;
        ev  = '0;
        mag = floor_root(axis_sq(s.x) + axis_sq(s.y) + axis_sq(s.z));
        dev = (mag >= 17'(GRAVITY_COUNTS)) ? mag - 17'(GRAVITY_COUNTS)
                                           : 17'(GRAVITY_COUNTS) - mag;

        if (dev >= 17'(det_cfg.motion_delta)) begin
            if (pred_motion_cnt != HIT_MAX) begin
                pred_motion_cnt = pred_motion_cnt + HIT_W'(1);
            end
            dt = s.t_us - last_motion_t;
            if (pred_motion_cnt >= HIT_W'(det_cfg.motion_need) &&
                dt >= TW'(det_cfg.motion_cool)) begin
                pred_motion_cnt = '0;
                last_motion_t   = s.t_us;
                ev.motion       = 1'b1;
            end
        end else begin
            pred_motion_cnt = '0;
        end

        case (det_cfg.level)
            LEVEL_LOW: thr = SHAKE_THR_LOW;
            LEVEL_MID: thr = SHAKE_THR_MID;
            default:   thr = SHAKE_THR_HIGH;
        endcase

        dt = s.t_us - first_hit_t;
        if (dev >= 17'(thr)) begin
            if (pred_shake_cnt == '0 || dt > TW'(det_cfg.shake_window)) begin
                pred_shake_cnt = HIT_W'(1);
                first_hit_t    = s.t_us;
            end else if (pred_shake_cnt != HIT_MAX) begin
                pred_shake_cnt = pred_shake_cnt + HIT_W'(1);
            end
            dt = s.t_us - last_shake_t;
            if (pred_shake_cnt >= HIT_W'(det_cfg.shake_need) &&
                dt > TW'(det_cfg.shake_cool)) begin
                pred_shake_cnt = '0;
                last_shake_t   = s.t_us;
                ev.shake       = 1'b1;
            end
        end else if (pred_shake_cnt != '0 && dt > TW'(det_cfg.shake_window)) begin
            pred_shake_cnt = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic exp, input logic got);
        $display("%0t ns: %s mismatch, expected %b, got %b", $time, what, exp, got);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_events want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (expected_events.size() == 0) begin
                report_mismatch("unrequested result", 1'b0, 1'b1);
            end else begin
                want = expected_events.pop_front();
                if (want.motion !== result_if.motion_event) begin
                    report_mismatch("motion_event", want.motion, result_if.motion_event);
                end
                if (want.shake !== result_if.shake_event) begin
                    report_mismatch("shake_event", want.shake, result_if.shake_event);
                end
            end
        end
    end

    // outside steady runs, hold ready high for random stretches and drop it for random bursts
    always @(negedge i_clk) begin
        if (steady_run) begin
            result_if.ready <= 1'b1;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (result_if.ready && $urandom_range(0, 2) == 0) begin
            result_if.ready <= 1'b0;
            ready_hold      <= $urandom_range(0, 16);
        end else begin
            result_if.ready <= 1'b1;
            ready_hold      <= $urandom_range(0, 40);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] wr_data;
        wr_data = (CFG_DATA_W'($urandom) & ~field_mask(idx)) | (value & field_mask(idx));
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= wr_data;
        do @(posedge i_clk); while (!cfg_if.ready);
        apply_reg(idx, wr_data);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_sample(input t_sample s, input bit typed, input t_events typed_ev);
        t_events ev;
        int      gap;
        @(negedge i_clk);
        if (!steady_run && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            sample_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        sample_if.valid   <= 1'b1;
        sample_if.accel_x <= s.x;
        sample_if.accel_y <= s.y;
        sample_if.accel_z <= s.z;
        sample_if.time_us <= s.t_us;
        do @(posedge i_clk); while (!sample_if.ready);
        compute_events(s, ev);
        if (typed) begin
            ev = typed_ev;
        end
        expected_events.push_back(ev);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        sample_if.valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_sample make_sample(input t_kind kind, input t_stamp t);
        t_sample s;
        int      big;
        int      axis;
        s.t_us = t;
        case (kind)
            KIND_QUIET: begin
                s.x = AW'(int'($urandom_range(0, 600)) - 300);
                s.y = AW'(int'($urandom_range(0, 600)) - 300);
                s.z = AW'(($urandom_range(0, 1) ? 8192 : -8192) + int'($urandom_range(0, 600)) - 300);
            end
            KIND_MOTION: begin
                s.x = AW'(int'($urandom_range(0, 3000)) - 1500);
                s.y = AW'(int'($urandom_range(0, 3000)) - 1500);
                s.z = AW'(int'($urandom_range(0, 40000)) - 20000);
            end
            KIND_SHAKE: begin
                big  = $urandom_range(0, 1) ? int'($urandom_range(15000, 32767))
                                            : -int'($urandom_range(15000, 32768));
                axis = $urandom_range(0, 2);
                s.x  = (axis == 0) ? AW'(big) : AW'(int'($urandom_range(0, 8000)) - 4000);
                s.y  = (axis == 1) ? AW'(big) : AW'(int'($urandom_range(0, 8000)) - 4000);
                s.z  = (axis == 2) ? AW'(big) : AW'(int'($urandom_range(0, 8000)) - 4000);
            end
            default: begin
                s.x = AW'($urandom);
                s.y = AW'($urandom);
                s.z = AW'($urandom);
            end
        endcase
        return s;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_time_reg();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return CFG_DATA_W'($urandom_range(0, 2000000));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_need();
        return ($urandom_range(0, 9) == 0) ? CFG_DATA_W'(15)
                                           : CFG_DATA_W'($urandom_range(0, 5));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_delta();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return CFG_DATA_W'(16'hFFFF);
            2:       return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(300, 4000));
        endcase
    endfunction

    task automatic randomize_config();
        if ($urandom_range(0, 9) < 7) write_reg(CFG_SENSITIVITY, CFG_DATA_W'($urandom_range(0, 3)));
        if ($urandom_range(0, 9) < 7) write_reg(CFG_MOTION_DELTA, rand_delta());
        if ($urandom_range(0, 9) < 7) write_reg(CFG_MOTION_NEED, rand_need());
        if ($urandom_range(0, 9) < 7) write_reg(CFG_MOTION_COOL, rand_time_reg());
        if ($urandom_range(0, 9) < 7) write_reg(CFG_SHAKE_NEED, rand_need());
        if ($urandom_range(0, 9) < 7) write_reg(CFG_SHAKE_WINDOW, rand_time_reg());
        if ($urandom_range(0, 9) < 7) write_reg(CFG_SHAKE_COOL, rand_time_reg());
        if ($urandom_range(0, 9) == 0) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
    endtask

    task automatic run_random_phase(input int n_items);
        t_stamp now;
        t_kind  kind;
        int     left;
        int     burst;
        int     pick;
        case ($urandom_range(0, 3))
            0:       now = TW'({$urandom, $urandom});
            1:       now = '1 - TW'($urandom_range(0, 3000000));
            default: now = clock_us + TW'($urandom_range(0, 3000000));
        endcase
        left = n_items;
        while (left > 0) begin
            pick = $urandom_range(0, 9);
            kind = (pick < 3) ? KIND_QUIET : (pick < 6) ? KIND_MOTION :
                   (pick < 9) ? KIND_SHAKE : KIND_NOISE;
            burst = $urandom_range(1, 20);
            if (burst > left) begin
                burst = left;
            end
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                now = TW'({$urandom, $urandom});
            end else if (pick < 6) begin
                now = now + TW'($urandom_range(0, 20000));
            end else begin
                now = now + TW'($urandom_range(0, 2000000));
            end
            repeat (burst) begin
                now = now + TW'($urandom_range(0, 8000));
                send_sample(make_sample(kind, now), 1'b0, '0);
            end
            left = left - burst;
        end
        clock_us = now;
        wait_drained();
    endtask

    // drive both hit counters into saturation while the cooldowns hold events back
    task automatic run_saturation();
        t_stamp t0;
        int     n_hits;
        write_reg(CFG_SENSITIVITY, CFG_DATA_W'(LEVEL_LOW));
        write_reg(CFG_MOTION_DELTA, CFG_DATA_W'(RST_MOTION_DELTA));
        write_reg(CFG_MOTION_NEED, CFG_DATA_W'(1));
        write_reg(CFG_SHAKE_NEED, CFG_DATA_W'(1));
        write_reg(CFG_MOTION_COOL, '0);
        write_reg(CFG_SHAKE_COOL, '0);
        write_reg(CFG_SHAKE_WINDOW, '1);
        t0 = last_shake_t + TW'(5000);
        send_sample(make_sample(KIND_SHAKE, t0), 1'b0, '0);
        wait_drained();
        write_reg(CFG_MOTION_NEED, CFG_DATA_W'(15));
        write_reg(CFG_SHAKE_NEED, CFG_DATA_W'(15));
        write_reg(CFG_MOTION_COOL, CFG_DATA_W'(1000));
        write_reg(CFG_SHAKE_COOL, CFG_DATA_W'(1000));
        n_hits = 256 + $urandom_range(0, 13);
        for (int i = 1; i <= n_hits; i++) begin
            send_sample(make_sample(KIND_SHAKE, t0 + TW'(i)), 1'b0, '0);
        end
        send_sample(make_sample(KIND_SHAKE, t0 + TW'(1500)), 1'b0, '0);
        clock_us = t0 + TW'(1500);
        wait_drained();
    endtask

    initial begin
        t_sample s;
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        sample_if.valid    = 1'b0;
        sample_if.accel_x  = '0;
        sample_if.accel_y  = '0;
        sample_if.accel_z  = '0;
        sample_if.time_us  = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = '0;
        cfg_if.data        = '0;
        steady_run         = 1'b0;
        items_sent         = 0;
        mismatch_count     = 0;
        clock_us           = '0;
        det_cfg = '{RST_SENSITIVITY, RST_MOTION_DELTA, RST_MOTION_NEED, RST_MOTION_COOL,
                    RST_SHAKE_NEED, RST_SHAKE_WINDOW, RST_SHAKE_COOL};
        pred_motion_cnt = '0;
        pred_shake_cnt  = '0;
        first_hit_t     = '0;
        last_shake_t    = '0;
        last_motion_t   = '0;

        dir_rows = '{
            '{16'sd0,      16'sd0,      16'sd8192,    48'd0,               1, 1'b0, 1'b0},
            '{16'sd0,      16'sd0,      16'sd0,       48'd100,             1, 1'b0, 1'b0},
            '{16'sd0,      16'sd0,      16'sd0,       48'd200,             1, 1'b0, 1'b0},
            '{16'sh8000,   16'sh8000,   16'sh8000,    48'd1200000,         1, 1'b1, 1'b0},
            '{16'sh7FFF,   16'sh7FFF,   16'sh7FFF,    48'd1200100,         1, 1'b0, 1'b0},
            '{16'sh7FFF,   16'sd0,      16'sd0,       48'd1200200,         1, 1'b0, 1'b1},
            '{16'sd0,      16'sd0,      -16'sd16384,  48'd1300000,         0, 1'b0, 1'b0},
            '{16'sd0,      16'sd8192,   16'sd0,       48'd1900000,         0, 1'b0, 1'b0},
            '{16'sd0,      16'sd0,      16'sd16384,   48'd1900100,         0, 1'b0, 1'b0},
            '{16'sd0,      16'sd18215,  16'sd0,       48'd3000000,         0, 1'b0, 1'b0},
            '{16'sd0,      16'sd0,      -16'sd18216,  48'd3000100,         0, 1'b0, 1'b0},
            '{16'sd9320,   16'sd0,      16'sd0,       48'd3000200,         0, 1'b0, 1'b0},
            '{16'sd0,      16'sd7064,   16'sd0,       48'd3000300,         0, 1'b0, 1'b0},
            '{16'sd0,      16'sd7065,   16'sd0,       48'd3000400,         0, 1'b0, 1'b0},
            '{-16'sd8192,  16'sd0,      16'sd0,       48'hFFFF_FFFF_FF9C,  0, 1'b0, 1'b0},
            '{16'sh7FFF,   16'sh7FFF,   16'sd0,       48'd50,              0, 1'b0, 1'b0},
            '{16'sd1,      -16'sd1,     16'sh8000,    48'hFFFF_FFFF_FFD8,  0, 1'b0, 1'b0}
        };

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            s.x    = dir_rows[i].x;
            s.y    = dir_rows[i].y;
            s.z    = dir_rows[i].z;
            s.t_us = dir_rows[i].t_us;
            send_sample(s, dir_rows[i].typed, {dir_rows[i].motion, dir_rows[i].shake});
        end
        clock_us = dir_rows[DIR_ROWS-1].t_us;
        wait_drained();

        write_reg(CFG_SENSITIVITY, CFG_DATA_W'(LEVEL_ALIAS));
        write_reg(CFG_MOTION_DELTA, '0);
        write_reg(CFG_MOTION_NEED, '0);
        write_reg(CFG_MOTION_COOL, '0);
        write_reg(CFG_SHAKE_NEED, '0);
        write_reg(CFG_SHAKE_WINDOW, '0);
        write_reg(CFG_SHAKE_COOL, '0);
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        run_random_phase(20);

        write_reg(CFG_SENSITIVITY, CFG_DATA_W'(LEVEL_HIGH));
        write_reg(CFG_MOTION_DELTA, CFG_DATA_W'(16'hFFFF));
        write_reg(CFG_MOTION_NEED, CFG_DATA_W'(15));
        write_reg(CFG_MOTION_COOL, '1);
        write_reg(CFG_SHAKE_NEED, CFG_DATA_W'(15));
        write_reg(CFG_SHAKE_WINDOW, '1);
        write_reg(CFG_SHAKE_COOL, '1);
        run_random_phase(20);

        run_saturation();

        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= ITEM_TARGET - STEADY_ITEMS) begin
                steady_run = 1'b1;
            end
            randomize_config();
            run_random_phase($urandom_range(20, 80));
        end
        wait_drained();

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
